@@ rtl/core/ghk_pkg.sv @@
// ----------------------------------------------------------------------------
// ghk_pkg
// Button bit positions, hotkey decode struct and screen mode helper for the
// gamepad hotkey and autofire core.
// ----------------------------------------------------------------------------
package ghk_pkg;

  // button bit positions within a pad word
  localparam int unsigned BtnA      = 0;
  localparam int unsigned BtnB      = 1;
  localparam int unsigned BtnSelect = 2;
  localparam int unsigned BtnStart  = 3;
  localparam int unsigned BtnUp     = 4;
  localparam int unsigned BtnDown   = 5;
  localparam int unsigned BtnLeft   = 6;
  localparam int unsigned BtnRight  = 7;

  localparam int unsigned PadWidth  = 8;
  localparam int unsigned MaskWidth = 2;
  localparam int unsigned ModeWidth = 2;
  localparam int unsigned StepWidth = 3;

  typedef logic [PadWidth-1:0]  pad_word_t;
  typedef logic [MaskWidth-1:0] af_mask_t;
  typedef logic [ModeWidth-1:0] scr_mode_t;

  // hotkey actions decoded from one pad in one poll
  typedef struct packed {
    logic     step_back;
    logic     step_fwd;
    logic     req;
    af_mask_t mask_toggle;
    logic     mode_up;
    logic     mode_down;
  } hotkey_t;

  // up steps the mode back, otherwise down steps it forward
  function automatic scr_mode_t next_mode(scr_mode_t mode, hotkey_t hk);
    scr_mode_t res;
    res = mode;
    if (hk.mode_up) begin
      res = mode - scr_mode_t'(1);
    end else if (hk.mode_down) begin
      res = mode + scr_mode_t'(1);
    end
    return res;
  endfunction

endpackage

@@ rtl/core/ghk_chan_if.sv @@
// ----------------------------------------------------------------------------
// ghk channel interfaces
// Valid/ready channels for the poll items and the result items.
// ----------------------------------------------------------------------------
interface ghk_poll_if;
  logic                 valid;
  logic                 ready;
  ghk_pkg::pad_word_t   pad_one_raw;
  ghk_pkg::pad_word_t   pad_two_raw;

  modport source (output valid, output pad_one_raw, output pad_two_raw, input ready);
  modport sink   (input valid, input pad_one_raw, input pad_two_raw, output ready);
endinterface

interface ghk_result_if;
  logic                 valid;
  logic                 ready;
  ghk_pkg::pad_word_t   pad_one_out;
  ghk_pkg::pad_word_t   pad_two_out;
  logic                 quit_request;
  logic                 save_request;
  logic signed [2:0]    rom_step;
  ghk_pkg::scr_mode_t   mode_now;
  logic                 scanline_on;
  logic                 scale_eight_seven;

  modport source (
    output valid, output pad_one_out, output pad_two_out, output quit_request,
    output save_request, output rom_step, output mode_now, output scanline_on,
    output scale_eight_seven, input ready
  );
  modport sink (
    input valid, input pad_one_out, input pad_two_out, input quit_request,
    input save_request, input rom_step, input mode_now, input scanline_on,
    input scale_eight_seven, output ready
  );
endinterface

@@ rtl/core/ghk_pad_decode.sv @@
// ----------------------------------------------------------------------------
// ghk_pad_decode
// Per-pad autofire masking and select-hotkey edge decode.
// ----------------------------------------------------------------------------
module ghk_pad_decode (
  input  ghk_pkg::pad_word_t now_i,
  input  ghk_pkg::pad_word_t prev_i,
  input  ghk_pkg::af_mask_t  mask_i,
  input  logic               fire_phase_i,
  output ghk_pkg::pad_word_t shown_o,
  output ghk_pkg::hotkey_t   hotkey_o
);
  import ghk_pkg::*;

  pad_word_t fresh;
  logic      sel;

  // newly pressed buttons
  assign fresh = now_i & ~prev_i;
  assign sel   = now_i[BtnSelect];

  // masked buttons drop out during the off half of the autofire cycle
  assign shown_o = fire_phase_i ? (now_i & ~{{(PadWidth-MaskWidth){1'b0}}, mask_i}) : now_i;

  always_comb begin
    hotkey_o.step_back   = sel & fresh[BtnLeft];
    hotkey_o.step_fwd    = sel & fresh[BtnRight];
    hotkey_o.req         = sel & (fresh[BtnLeft] | fresh[BtnRight] | fresh[BtnStart]);
    hotkey_o.mask_toggle = {sel & fresh[BtnB], sel & fresh[BtnA]};
    hotkey_o.mode_up     = sel & fresh[BtnUp];
    hotkey_o.mode_down   = sel & fresh[BtnDown];
  end

endmodule

@@ rtl/core/gamepad_hotkey_autofire_core.sv @@
// ----------------------------------------------------------------------------
// gamepad_hotkey_autofire_core
// Autofire masking and select hotkeys for two gamepads.
// ----------------------------------------------------------------------------
// Usage:
//   poll_i carries one item per poll: the raw button words of both pads.
//   result_o carries one item per poll: the masked pad words, the save and
//   quit requests, the net rom step and the screen mode after the poll.
//   An item is accepted when valid and ready are high at a rising edge.
//   The result of an item sits in the output register in the cycle after it
//   is accepted. Throughput is one item per cycle while the receiver takes
//   results; the pad history, autofire masks, poll counter and screen mode
//   all update in the accept cycle, so the next item can follow at once.
//   While the receiver stalls with a result held, poll_i.ready stays low;
//   it rises in the cycle the held result is taken.
//   Reset clears the pad history, the autofire masks, the poll counter and
//   the screen mode (scanlines, 8:7), and empties the output register.
// ----------------------------------------------------------------------------
module gamepad_hotkey_autofire_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  ghk_poll_if.sink     poll_i,
  ghk_result_if.source result_o
);
  import ghk_pkg::*;

  pad_word_t         prev_q [2];
  pad_word_t         prev_d [2];
  af_mask_t          mask_q [2];
  af_mask_t          mask_d [2];
  logic [1:0]        cnt_q, cnt_d;
  scr_mode_t         mode_q, mode_d, mode_mid;
  logic              accept;

  pad_word_t         shown [2];
  hotkey_t           hk [2];
  pad_word_t         raw [2];
  logic signed [StepWidth-1:0] step;

  logic              out_valid_q;
  pad_word_t         out_one_q, out_two_q;
  logic              out_req_q;
  logic signed [StepWidth-1:0] out_step_q;
  scr_mode_t         out_mode_q;

  assign raw[0] = poll_i.pad_one_raw;
  assign raw[1] = poll_i.pad_two_raw;

  assign poll_i.ready = !out_valid_q || result_o.ready;
  assign accept       = poll_i.valid && poll_i.ready;

  assign cnt_d = cnt_q + 2'd1;

  for (genvar k = 0; k < 2; k++) begin : g_pad
    ghk_pad_decode u_dec (
      .now_i        (raw[k]),
      .prev_i       (prev_q[k]),
      .mask_i       (mask_q[k]),
      .fire_phase_i (cnt_d[1]),
      .shown_o      (shown[k]),
      .hotkey_o     (hk[k])
    );
    assign prev_d[k] = raw[k];
    assign mask_d[k] = mask_q[k] ^ hk[k].mask_toggle;
  end

  // pad one acts on the mode before pad two
  assign mode_mid = next_mode(mode_q, hk[0]);
  assign mode_d   = next_mode(mode_mid, hk[1]);

  assign step = StepWidth'(hk[0].step_fwd) + StepWidth'(hk[1].step_fwd)
              - StepWidth'(hk[0].step_back) - StepWidth'(hk[1].step_back);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q[0] <= '0;
      prev_q[1] <= '0;
      mask_q[0] <= '0;
      mask_q[1] <= '0;
      cnt_q     <= '0;
      mode_q    <= '0;
    end else if (accept) begin
      prev_q[0] <= prev_d[0];
      prev_q[1] <= prev_d[1];
      mask_q[0] <= mask_d[0];
      mask_q[1] <= mask_d[1];
      cnt_q     <= cnt_d;
      mode_q    <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_one_q  <= shown[0];
      out_two_q  <= shown[1];
      out_req_q  <= hk[0].req | hk[1].req;
      out_step_q <= step;
      out_mode_q <= mode_d;
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.pad_one_out       = out_one_q;
  assign result_o.pad_two_out       = out_two_q;
  assign result_o.quit_request      = out_req_q;
  assign result_o.save_request      = out_req_q;
  assign result_o.rom_step          = out_step_q;
  assign result_o.mode_now          = out_mode_q;
  assign result_o.scanline_on       = ~out_mode_q[0];
  assign result_o.scale_eight_seven = ~out_mode_q[1];

  // a nonzero rom step always comes with a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_step_q != '0) |-> out_req_q)
    else $error("rom step without save request");

  // the step stays within two presses either way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_step_q != 3'sd3) && (out_step_q != -3'sd3)
                 && (out_step_q != -3'sd4))
    else $error("rom step out of range");

  // the poll counter advances once per accepted item and holds otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("poll counter did not advance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(cnt_q) && $stable(mode_q))
    else $error("state changed without an item");

  // the reported mode is the live mode while the result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_mode_q == mode_q)
    else $error("reported mode differs from live mode");

endmodule

@@ tb/sv/gamepad_hotkey_autofire_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gamepad_hotkey_autofire_core_test
// Self-checking bench for the hotkey and autofire core. Poll items come from
// a queue filled with a directed opening and random button traffic, and both
// channels idle in random bursts. Every accepted poll is run through a local
// model of the pad history, autofire masks, poll counter and screen mode. Each
// result item is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module gamepad_hotkey_autofire_core_test;
  import ghk_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomPolls = 550;
  localparam int unsigned QuietPolls  = 60;
  localparam int unsigned ShowLimit   = 10;

  localparam pad_word_t KeyA     = pad_word_t'(1 << BtnA);
  localparam pad_word_t KeyB     = pad_word_t'(1 << BtnB);
  localparam pad_word_t KeySel   = pad_word_t'(1 << BtnSelect);
  localparam pad_word_t KeyStart = pad_word_t'(1 << BtnStart);
  localparam pad_word_t KeyUp    = pad_word_t'(1 << BtnUp);
  localparam pad_word_t KeyDown  = pad_word_t'(1 << BtnDown);
  localparam pad_word_t KeyLeft  = pad_word_t'(1 << BtnLeft);
  localparam pad_word_t KeyRight = pad_word_t'(1 << BtnRight);

  typedef struct {
    pad_word_t pad_one;
    pad_word_t pad_two;
    bit        drain;
    bit        quiet;
  } poll_item_t;

  typedef struct packed {
    pad_word_t         pad_one;
    pad_word_t         pad_two;
    logic              quit;
    logic              save;
    logic signed [2:0] step;
    scr_mode_t         mode;
    logic              scanline;
    logic              scale;
  } poll_result_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        drv_valid   = 1'b0;
  pad_word_t   drv_one     = '0;
  pad_word_t   drv_two     = '0;
  logic        rx_ready    = 1'b0;
  logic        quiet_tail  = 1'b0;
  logic [31:0] cycle_count = '0;
  logic        idle_allowed;
  int          send_gap;
  int          take_gap;
  int          mismatch_count = 0;

  poll_item_t   pending_polls[$];
  poll_result_t expected_results[$];

  // local copy of the core state
  pad_word_t held_buttons[2];
  af_mask_t  turbo_mask[2];
  logic [1:0] poll_phase;
  scr_mode_t screen_mode_q;

  ghk_poll_if   poll_ch();
  ghk_result_if res_ch();

  assign poll_ch.valid       = drv_valid;
  assign poll_ch.pad_one_raw = drv_one;
  assign poll_ch.pad_two_raw = drv_two;
  assign res_ch.ready        = rx_ready;

  gamepad_hotkey_autofire_core u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .poll_i   (poll_ch),
    .result_o (res_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // a quarter of the time neither side starts a new idle burst
  assign idle_allowed = !quiet_tail && (cycle_count[7:6] != 2'b11);

  function automatic void queue_poll(pad_word_t one, pad_word_t two, bit drain, bit quiet);
    poll_item_t item;
    item.pad_one = one;
    item.pad_two = two;
    item.drain   = drain;
    item.quiet   = quiet;
    pending_polls.push_back(item);
  endfunction

  // biased toward select hotkeys with fresh presses
  function automatic pad_word_t next_press(pad_word_t last);
    pad_word_t w;
    w = last;
    case ($urandom_range(0, 9))
      0, 1, 2: w = pad_word_t'($urandom);
      3, 4, 5: begin
        w = KeySel | pad_word_t'(1 << $urandom_range(0, 7));
        if ($urandom_range(0, 2) == 0) begin
          w = w | pad_word_t'(1 << $urandom_range(0, 7));
        end
      end
      6, 7: w = ($urandom_range(0, 1) != 0) ? KeySel : '0;
      default: w = last;
    endcase
    return w;
  endfunction

  function automatic void predict_poll(pad_word_t one, pad_word_t two);
    pad_word_t    raw[2];
    pad_word_t    now;
    pad_word_t    fresh;
    pad_word_t    shown[2];
    logic         req;
    int           step;
    poll_result_t res;
    raw[0] = one;
    raw[1] = two;
    req  = 1'b0;
    step = 0;
    poll_phase = poll_phase + 2'd1;
    for (int k = 0; k < 2; k++) begin
      now = raw[k];
      shown[k] = now;
      // masking uses the mask from before this poll
      if (poll_phase[1]) begin
        shown[k] = now & ~{6'b0, turbo_mask[k]};
      end
      fresh = now & ~held_buttons[k];
      if (now[BtnSelect]) begin
        if (fresh[BtnLeft]) begin
          step = step - 1;
          req  = 1'b1;
        end
        if (fresh[BtnRight]) begin
          step = step + 1;
          req  = 1'b1;
        end
        if (fresh[BtnStart]) begin
          req = 1'b1;
        end
        if (fresh[BtnA]) begin
          turbo_mask[k][BtnA] = ~turbo_mask[k][BtnA];
        end
        if (fresh[BtnB]) begin
          turbo_mask[k][BtnB] = ~turbo_mask[k][BtnB];
        end
        if (fresh[BtnUp]) begin
          screen_mode_q = screen_mode_q - 2'd1;
        end else if (fresh[BtnDown]) begin
          screen_mode_q = screen_mode_q + 2'd1;
        end
      end
      held_buttons[k] = now;
    end
    res.pad_one  = shown[0];
    res.pad_two  = shown[1];
    res.quit     = req;
    res.save     = req;
    res.step     = 3'(step);
    res.mode     = screen_mode_q;
    res.scanline = ~screen_mode_q[0];
    res.scale    = ~screen_mode_q[1];
    expected_results.push_back(res);
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= ShowLimit) begin
        $display("mismatch on %s: expected %h, got %h", field, want, got);
      end
    end
  endfunction

  always @(posedge clk or negedge rst_n) begin : poll_driver
    poll_item_t item;
    logic       accepted;
    if (!rst_n) begin
      drv_valid     <= 1'b0;
      drv_one       <= '0;
      drv_two       <= '0;
      quiet_tail    <= 1'b0;
      send_gap      = 0;
      held_buttons  = '{default: '0};
      turbo_mask    = '{default: '0};
      poll_phase    = '0;
      screen_mode_q = '0;
    end else begin
      accepted = drv_valid && poll_ch.ready;
      if (accepted) begin
        predict_poll(drv_one, drv_two);
      end
      if (!drv_valid || accepted) begin
        if (send_gap > 0) begin
          send_gap--;
          drv_valid <= 1'b0;
        end else if (pending_polls.size() == 0 ||
                     (pending_polls[0].drain && expected_results.size() != 0)) begin
          drv_valid <= 1'b0;
        end else if (idle_allowed && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 15) - 1;
          drv_valid <= 1'b0;
        end else begin
          item = pending_polls.pop_front();
          if (item.quiet) begin
            quiet_tail <= 1'b1;
          end
          drv_valid <= 1'b1;
          drv_one   <= item.pad_one;
          drv_two   <= item.pad_two;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : result_monitor
    poll_result_t want;
    if (!rst_n) begin
      rx_ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (res_ch.valid && rx_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ShowLimit) begin
            $display("result item with no poll pending: pads %h %h",
                     res_ch.pad_one_out, res_ch.pad_two_out);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("pad_one_out", want.pad_one, res_ch.pad_one_out);
          check_field("pad_two_out", want.pad_two, res_ch.pad_two_out);
          check_field("quit_request", {7'b0, want.quit}, {7'b0, res_ch.quit_request});
          check_field("save_request", {7'b0, want.save}, {7'b0, res_ch.save_request});
          check_field("rom_step", {5'b0, want.step}, {5'b0, res_ch.rom_step});
          check_field("mode_now", {6'b0, want.mode}, {6'b0, res_ch.mode_now});
          check_field("scanline_on", {7'b0, want.scanline}, {7'b0, res_ch.scanline_on});
          check_field("scale_eight_seven", {7'b0, want.scale},
                      {7'b0, res_ch.scale_eight_seven});
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        rx_ready <= 1'b0;
      end else if (idle_allowed && $urandom_range(0, 5) == 0) begin
        take_gap = $urandom_range(1, 15) - 1;
        rx_ready <= 1'b0;
      end else begin
        rx_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 32'd1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    pad_word_t last_one;
    pad_word_t last_two;

    // directed opening
    queue_poll('0, '0, 1'b0, 1'b0);
    queue_poll('1, '1, 1'b0, 1'b0);  // every hotkey fresh at once on both pads
    queue_poll('0, '0, 1'b0, 1'b0);
    queue_poll(KeySel | KeyA, '0, 1'b0, 1'b0);
    queue_poll('0, KeySel | KeyB, 1'b0, 1'b0);
    queue_poll(KeySel | KeyRight, KeySel | KeyLeft, 1'b0, 1'b0);
    queue_poll('0, '0, 1'b0, 1'b0);
    queue_poll(KeySel | KeyRight, KeySel | KeyRight, 1'b0, 1'b0);
    queue_poll('0, '0, 1'b0, 1'b0);
    queue_poll(KeySel | KeyLeft, KeySel | KeyLeft, 1'b0, 1'b0);
    queue_poll(KeySel, KeySel, 1'b0, 1'b0);
    queue_poll(KeySel | KeyStart, KeySel, 1'b0, 1'b0);
    queue_poll(KeySel | KeyDown, '0, 1'b0, 1'b0);
    queue_poll(KeySel | KeyUp, KeySel | KeyDown, 1'b0, 1'b0);
    queue_poll('0, '0, 1'b0, 1'b0);
    queue_poll(KeySel | KeyUp | KeyDown, KeySel | KeyLeft | KeyRight, 1'b0, 1'b0);
    queue_poll(KeyLeft | KeyRight | KeyStart, KeyUp | KeyA, 1'b0, 1'b0);
    // select arrives after the buttons: no hotkey button is fresh
    queue_poll(KeyLeft | KeyRight | KeyStart | KeySel, KeyUp | KeyA | KeySel, 1'b0, 1'b0);
    for (int i = 0; i < 5; i++) begin
      queue_poll(KeyA | KeyB | KeySel, KeyA | KeyB, 1'b0, 1'b0);
    end
    queue_poll('1, '1, 1'b0, 1'b0);

    // random traffic, drained now and then
    last_one = '0;
    last_two = '0;
    for (int i = 0; i < RandomPolls; i++) begin
      last_one = next_press(last_one);
      last_two = next_press(last_two);
      queue_poll(last_one, last_two, (i % 137) == 0, i >= RandomPolls - QuietPolls);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_polls.size() != 0 || drv_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
